// ----- sv/cube_state_coordinate_encoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cube state coordinate encoder
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CUBE_STATE_COORDINATE_ENCODER_TOP_ASSERT_SVH
`define CUBE_STATE_COORDINATE_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CSE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cse assertion failed");
`define CSE_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("cse assertion failed");
`else
`define CSE_ASSERT(name, clk, rst_n, prop)
`define CSE_ASSERT_NR(name, clk, prop)
`endif

`endif

// ----- sv/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// Cube state encoder package
// Sizes, factorial and power tables, and shared control types.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int CORNERS     = 8;
  localparam int EDGES       = 12;
  localparam int CP_W        = 3;
  localparam int CT_W        = 2;
  localparam int EP_W        = 4;
  localparam int CRANK_W     = 16;
  localparam int ERANK_W     = 29;
  localparam int TWIST_W     = 12;
  localparam int FLIP_W      = 11;
  localparam int TWIST_BASE  = 3;
  localparam int MERGE_GROUP = 4;

  localparam logic [31:0] FACT_TAB [EDGES] = '{
    32'd1, 32'd1, 32'd2, 32'd6, 32'd24, 32'd120, 32'd720, 32'd5040,
    32'd40320, 32'd362880, 32'd3628800, 32'd39916800
  };

  localparam logic [TWIST_W-1:0] POW3_TAB [CORNERS-1] = '{
    12'd1, 12'd3, 12'd9, 12'd27, 12'd81, 12'd243, 12'd729
  };

  typedef struct packed {
    logic ld_part;
    logic ld_sum;
  } merge_en_t;

endpackage

// ----- sv/cse_lane.sv -----
// ----------------------------------------------------------------------------
// Lehmer lane
// Counts later positions holding a smaller value and weights the count by
// the factorial of the remaining length.
// ----------------------------------------------------------------------------
module cse_lane #(
  parameter int N      = 8,
  parameter int VAL_W  = 3,
  parameter int POS    = 0,
  parameter int TERM_W = 16
) (
  input  logic [N-1:0][VAL_W-1:0] vals,
  output logic [TERM_W-1:0]       term
);

  localparam int CNT_W = $clog2(N);
  localparam logic [TERM_W-1:0] FACT_W = TERM_W'(cse_pkg::FACT_TAB[N-1-POS]);

  logic [CNT_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int j = 0; j < N; j++) begin
      if (j > POS && vals[j] < vals[POS]) begin
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  assign term = TERM_W'(cnt) * FACT_W;

endmodule

// ----- sv/cse_merge.sv -----
// ----------------------------------------------------------------------------
// Lane merge tree
// Two registered levels: groups of four lane terms, then the group sums.
// ----------------------------------------------------------------------------
module cse_merge #(
  parameter int N = 8,
  parameter int W = 16
) (
  input  logic                clk,
  input  cse_pkg::merge_en_t  en,
  input  logic [N-1:0][W-1:0] terms,
  output logic [W-1:0]        sum_r
);

  localparam int GROUP = cse_pkg::MERGE_GROUP;
  localparam int NG    = (N + GROUP - 1) / GROUP;

  logic [NG*GROUP-1:0][W-1:0] terms_pad;
  logic [NG-1:0][W-1:0]       part_nxt;
  logic [NG-1:0][W-1:0]       part_r;
  logic [W-1:0]               sum_nxt;

  always_comb begin
    terms_pad = '0;
    terms_pad[N-1:0] = terms;
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        part_nxt[g] = part_nxt[g] + terms_pad[g*GROUP+k];
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      sum_nxt = sum_nxt + part_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_part) begin
      part_r <= part_nxt;
    end
    if (en.ld_sum) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ----- sv/cube_state_coordinate_encoder_top.sv -----
// ----------------------------------------------------------------------------
// Cube state coordinate encoder
// Turns one packed cube state into permutation ranks and orientation indices.
//
// The input channel (in_valid/in_ready) carries one whole cube state per beat:
// corner and edge permutations, corner twists and edge flips. The output
// channel (out_valid/out_ready) returns one beat per input beat, in order,
// with both Lehmer ranks, the base-3 twist index, the binary flip index and
// bad_state. A state with a repeated or out-of-range piece or a twist of 3
// gives bad_state high and all four coordinates zero.
// A beat passes the stage-1, partial-sum and output registers in turn.
// One beat per cycle unless out_ready stalls: a lane per position ranks all
// positions at once; the merge tree sums lane terms over two registered levels.
// Each pipeline stage advances when the stage after it is empty or moving,
// so a stalled receiver holds the output beat while upstream bubbles fill.
// in_ready falls only once all three stages hold a beat.
// Reset (rst_n low, synchronous) empties the pipeline; no other state.
// ----------------------------------------------------------------------------
`include "cube_state_coordinate_encoder_top_assert.svh"

module cube_state_coordinate_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_corner_perm_packed,
  input  logic [15:0] in_corner_twist_packed,
  input  logic [47:0] in_edge_perm_packed,
  input  logic [11:0] in_edge_flip_packed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_corner_perm_rank,
  output logic [11:0] out_corner_twist_index,
  output logic [28:0] out_edge_perm_rank,
  output logic [10:0] out_edge_flip_index,
  output logic        out_bad_state
);

  localparam int NC = cse_pkg::CORNERS;
  localparam int NE = cse_pkg::EDGES;
  localparam int CW = cse_pkg::CRANK_W;
  localparam int EW = cse_pkg::ERANK_W;
  localparam int TW = cse_pkg::TWIST_W;
  localparam int FW = cse_pkg::FLIP_W;

  logic [NC-1:0][cse_pkg::CP_W-1:0] cp;
  logic [NC-1:0][cse_pkg::CT_W-1:0] ct;
  logic [NE-1:0][cse_pkg::EP_W-1:0] ep;
  logic [NE-1:0]                    ef;

  logic [NC-1:0][CW-1:0] cterm;
  logic [NE-1:0][EW-1:0] eterm;
  logic                  bad;
  logic [TW-1:0]         twist;
  logic [FW-1:0]         flip;

  logic                  s1_v_r, s2_v_r, out_v_r;
  logic                  s1_adv, s2_adv, s3_adv;
  logic [NC-1:0][CW-1:0] s1_cterm_r;
  logic [NE-1:0][EW-1:0] s1_eterm_r;
  logic [TW-1:0]         s1_twist_r, s2_twist_r, out_twist_r;
  logic [FW-1:0]         s1_flip_r, s2_flip_r, out_flip_r;
  logic                  s1_bad_r, s2_bad_r, out_bad_r;
  cse_pkg::merge_en_t    men;
  logic                  out_coords_zero;
  logic                  out_coords_in_range;

  assign cp = in_corner_perm_packed;
  assign ct = in_corner_twist_packed;
  assign ep = in_edge_perm_packed;
  assign ef = in_edge_flip_packed;

  for (genvar i = 0; i < NC; i++) begin : g_clane
    cse_lane #(.N(NC), .VAL_W(cse_pkg::CP_W), .POS(i), .TERM_W(CW)) u_lane (
      .vals (cp),
      .term (cterm[i])
    );
  end

  for (genvar i = 0; i < NE; i++) begin : g_elane
    cse_lane #(.N(NE), .VAL_W(cse_pkg::EP_W), .POS(i), .TERM_W(EW)) u_lane (
      .vals (ep),
      .term (eterm[i])
    );
  end

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        if (j > i && cp[i] == cp[j]) begin
          bad = 1'b1;
        end
      end
      if (ct[i] >= cse_pkg::CT_W'(cse_pkg::TWIST_BASE)) begin
        bad = 1'b1;
      end
    end
    for (int i = 0; i < NE; i++) begin
      for (int j = 0; j < NE; j++) begin
        if (j > i && ep[i] == ep[j]) begin
          bad = 1'b1;
        end
      end
      if (ep[i] >= cse_pkg::EP_W'(NE)) begin
        bad = 1'b1;
      end
    end
  end

  always_comb begin
    twist = '0;
    for (int i = 0; i < NC - 1; i++) begin
      twist = twist + TW'(ct[i]) * cse_pkg::POW3_TAB[NC-2-i];
    end
    for (int i = 0; i < FW; i++) begin
      flip[FW-1-i] = ef[i];
    end
  end

  assign s3_adv   = !out_v_r || out_ready;
  assign s2_adv   = !s2_v_r || s3_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  assign men.ld_part = s1_v_r && s2_adv;
  assign men.ld_sum  = s2_v_r && s3_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cterm_r <= bad ? '0 : cterm;
      s1_eterm_r <= bad ? '0 : eterm;
      s1_twist_r <= bad ? '0 : twist;
      s1_flip_r  <= bad ? '0 : flip;
      s1_bad_r   <= bad;
    end
    if (men.ld_part) begin
      s2_twist_r <= s1_twist_r;
      s2_flip_r  <= s1_flip_r;
      s2_bad_r   <= s1_bad_r;
    end
    if (men.ld_sum) begin
      out_twist_r <= s2_twist_r;
      out_flip_r  <= s2_flip_r;
      out_bad_r   <= s2_bad_r;
    end
  end

  cse_merge #(.N(NC), .W(CW)) u_cmerge (
    .clk   (clk),
    .en    (men),
    .terms (s1_cterm_r),
    .sum_r (out_corner_perm_rank)
  );

  cse_merge #(.N(NE), .W(EW)) u_emerge (
    .clk   (clk),
    .en    (men),
    .terms (s1_eterm_r),
    .sum_r (out_edge_perm_rank)
  );

  assign out_valid              = out_v_r;
  assign out_corner_twist_index = out_twist_r;
  assign out_edge_flip_index    = out_flip_r;
  assign out_bad_state          = out_bad_r;

  assign out_coords_zero = out_corner_perm_rank == 16'd0 && out_edge_perm_rank == 29'd0 &&
                           out_corner_twist_index == 12'd0 && out_edge_flip_index == 11'd0;
  assign out_coords_in_range = out_corner_perm_rank < 16'd40320 &&
                               out_edge_perm_rank < 29'd479001600 &&
                               out_corner_twist_index < 12'd2187;

  `CSE_ASSERT(a_bad_zero, clk, rst_n, (out_valid && out_bad_state) |-> out_coords_zero)
  `CSE_ASSERT(a_rank_range, clk, rst_n, (out_valid && !out_bad_state) |-> out_coords_in_range)
  `CSE_ASSERT(a_accept_while_held, clk, rst_n, (out_valid && !out_ready && !s2_v_r) |-> in_ready)
  `CSE_ASSERT(a_s2_holds, clk, rst_n, (s2_v_r && out_valid && !out_ready) |=> s2_v_r)
  `CSE_ASSERT_NR(a_reset_empty, clk, !rst_n |=> (!out_valid && in_ready))

endmodule
